/* src/quadrature_encoder_position_velocity_top_macros.svh */
// Assertion macros shared by the encoder block's RTL files.
// Expects clk and rst (synchronous, active high) in the including scope.
`ifndef QUADRATURE_ENCODER_POSITION_VELOCITY_TOP_MACROS_SVH
`define QUADRATURE_ENCODER_POSITION_VELOCITY_TOP_MACROS_SVH

// same-cycle implication
`define QEPV_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("qepv same-cycle check failed");

// next-cycle implication
`define QEPV_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("qepv next-cycle check failed");

`endif

/* src/qepv_pkg.sv */
// Shared types, register indexes, step table and saturation helper for
// the quadrature encoder block. No dependencies.
`default_nettype none

package qepv_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_WINDOW_MS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_SCALE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEG_FACTOR         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_POSITION      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ARRIVAL_THRESHOLD  = 3'd4;

  localparam logic [15:0] WINDOW_RESET  = 16'd10;
  localparam logic [31:0] DEGREES_RESET = 32'h0001_0000;

  // step codes
  localparam logic [1:0] STEP_HOLD    = 2'd0;
  localparam logic [1:0] STEP_UP      = 2'd1;
  localparam logic [1:0] STEP_DOWN    = 2'd2;
  localparam logic [1:0] STEP_ILLEGAL = 2'd3;

  // indexed by {new_ab, previous_ab}
  localparam logic [1:0] STEP_TABLE [0:15] = '{
    STEP_HOLD,    STEP_DOWN,    STEP_UP,      STEP_ILLEGAL,
    STEP_UP,      STEP_HOLD,    STEP_ILLEGAL, STEP_DOWN,
    STEP_DOWN,    STEP_ILLEGAL, STEP_HOLD,    STEP_UP,
    STEP_ILLEGAL, STEP_UP,      STEP_DOWN,    STEP_HOLD
  };

  typedef struct packed {
    logic [31:0] count;
    logic [15:0] error;
    logic        illegal;
    logic        fire;
    logic [31:0] delta;
  } track_t;

  // magnitude q with sign neg, saturated to signed 32 bits
  function automatic logic [31:0] sat_signed32(input logic neg, input logic [63:0] q);
    logic [31:0] res;
    if (neg) begin
      if (q > 64'h0000_0000_8000_0000) res = 32'h8000_0000;
      else res = 32'd0 - q[31:0];
    end else begin
      if (q > 64'h0000_0000_7FFF_FFFF) res = 32'h7FFF_FFFF;
      else res = q[31:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* src/quadrature_encoder_position_velocity_top.sv */
// Top level of the quadrature encoder block: config registers and the result
// pipeline. Depends on qepv_pkg, qepv_track and the assertion macro header.
`default_nettype none
`include "quadrature_encoder_position_velocity_top_macros.svh"

// Channel   Handshake              Payload
// --------  ---------------------  -----------------------------------------
// in        in_valid / in_ready    func, pin_a, pin_b
// out       out_valid / out_ready  position_count, position_degrees,
//                                  error_total, velocity, illegal_step,
//                                  at_target
// config    wr_en (no wait)        wr_index, wr_data
//
// One request accepted per cycle while in_ready is high; its result moves from the stage 1
// capture through stages 2 and 3 into the output register, where out_valid rises.
// Encoder state updates at acceptance, so back-to-back samples chain through one
// +/-1 adder. Each 32x32 multiply (degrees, velocity) takes one stage after a
// magnitude stage; saturation lands in the output register. Every stage has its
// own valid bit, so in_ready drops only once all four stages hold requests.

module quadrature_encoder_position_velocity_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // config write port
  input  wire logic                           wr_en,
  input  wire logic [qepv_pkg::CFG_IDX_W-1:0] wr_index,
  input  wire logic [31:0]                    wr_data,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           func,
  input  wire logic                           pin_a,
  input  wire logic                           pin_b,
  // output channel
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [31:0]                  position_count,
  output logic signed [31:0]                  position_degrees,
  output logic        [15:0]                  error_total,
  output logic signed [31:0]                  velocity,
  output logic                                illegal_step,
  output logic                                at_target
);
  import qepv_pkg::*;

  // ---------------- configuration registers ----------------
  // synchronous reset returns these to their defaults
  logic [15:0] velocity_window_ms;
  logic [31:0] velocity_scale;
  logic [31:0] deg_factor;
  logic [31:0] goal_position;
  logic [15:0] arrival_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      velocity_window_ms <= WINDOW_RESET;
      velocity_scale     <= 32'd0;
      deg_factor         <= DEGREES_RESET;
      goal_position      <= 32'd0;
      arrival_threshold  <= 16'd0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_VELOCITY_WINDOW_MS: velocity_window_ms <= wr_data[15:0];
        REG_VELOCITY_SCALE:     velocity_scale     <= wr_data;
        REG_DEG_FACTOR:         deg_factor         <= wr_data;
        REG_GOAL_POSITION:      goal_position      <= wr_data;
        REG_ARRIVAL_THRESHOLD:  arrival_threshold  <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  // ---------------- stall chain ----------------
  // a stage may load when it is empty or the stage after it loads
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3, rdy4;
  logic accept;

  assign rdy4     = !out_valid || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;
  assign accept   = in_valid && in_ready;

  // ---------------- stage 0: encoder state ----------------
  track_t upd;

  qepv_track u_track (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .func   (func),
    .pin_a  (pin_a),
    .pin_b  (pin_b),
    .window (velocity_window_ms),
    .upd    (upd)
  );

  // ---------------- stage 1: captured update ----------------
  track_t t1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (rdy1) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (accept) t1 <= upd;
  end

  // ---------------- stage 2: magnitudes, arrival difference ----------------
  logic [31:0] cnt2, cmag2, dmag2;
  logic [15:0] err2;
  logic        ill2, fire2, cneg2, dneg2;
  logic [32:0] diff2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (rdy2) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      cnt2  <= t1.count;
      err2  <= t1.error;
      ill2  <= t1.illegal;
      fire2 <= t1.fire;
      cneg2 <= t1.count[31];
      cmag2 <= t1.count[31] ? 32'd0 - t1.count : t1.count;
      dneg2 <= t1.delta[31];
      dmag2 <= t1.delta[31] ? 32'd0 - t1.delta : t1.delta;
      // exact signed difference, no wrap
      diff2 <= {goal_position[31], goal_position} - {t1.count[31], t1.count};
    end
  end

  // ---------------- stage 3: products, arrival compare ----------------
  logic [31:0] cnt3;
  logic [15:0] err3;
  logic        ill3, fire3, cneg3, dneg3, at3;
  logic [63:0] cprod3, dprod3;
  logic [32:0] absdiff2;

  assign absdiff2 = diff2[32] ? 33'd0 - diff2 : diff2;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (rdy3) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      cnt3   <= cnt2;
      err3   <= err2;
      ill3   <= ill2;
      fire3  <= fire2;
      cneg3  <= cneg2;
      dneg3  <= dneg2;
      cprod3 <= {32'd0, cmag2} * {32'd0, deg_factor};
      dprod3 <= {32'd0, dmag2} * {32'd0, velocity_scale};
      at3    <= absdiff2 < {17'd0, arrival_threshold};
    end
  end

  // ---------------- stage 4: saturate into output register ----------------
  // velocity is held state: it changes only when a window-firing tick lands here
  logic [31:0] velocity_reg;
  logic [31:0] degrees_reg;
  logic [31:0] count_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      velocity_reg <= 32'd0;
    end else if (rdy4) begin
      out_valid <= v3;
      if (v3 && fire3) begin
        // Q8.24 scale times counts, down to Q16.16
        velocity_reg <= sat_signed32(dneg3, {8'd0, dprod3[63:8]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      count_out    <= cnt3;
      degrees_reg  <= sat_signed32(cneg3, {16'd0, cprod3[63:16]});
      error_total  <= err3;
      illegal_step <= ill3;
      at_target    <= at3;
    end
  end

  assign position_count   = count_out;
  assign position_degrees = degrees_reg;
  assign velocity         = velocity_reg;

  // input stalls only behind a full pipeline held by the output side
  `QEPV_ASSERT_NOW(a_stall_cause, !in_ready, out_valid && !out_ready && v1 && v2 && v3)
  // a held result keeps its velocity even if a firing tick waits behind it
  `QEPV_ASSERT_NEXT(a_velocity_hold, out_valid && !out_ready,
                    velocity_reg == $past(velocity_reg))
  // an illegal jump is a sample, never a tick
  `QEPV_ASSERT_NOW(a_illegal_not_tick, v1 && t1.illegal, !t1.fire)

endmodule

`default_nettype wire

/* src/qepv_track.sv */
// Encoder state: step decode, position/error counts, window timer, snapshot.
// Depends on qepv_pkg and the assertion macro header.
`default_nettype none
`include "quadrature_encoder_position_velocity_top_macros.svh"

module qepv_track (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           accept,
  input  wire logic           func,
  input  wire logic           pin_a,
  input  wire logic           pin_b,
  input  wire logic [15:0]    window,
  output qepv_pkg::track_t    upd
);
  import qepv_pkg::*;

  logic [1:0]  previous_ab;
  logic [31:0] count_reg;
  logic [15:0] error_reg;
  logic [15:0] elapsed_ms;
  logic [31:0] count_snapshot;

  logic [1:0]  ab;
  logic [1:0]  code;
  logic [16:0] elapsed_inc;
  logic        is_sample;

  assign ab          = {pin_a, pin_b};
  assign code        = STEP_TABLE[{ab, previous_ab}];
  assign is_sample   = !func;
  assign elapsed_inc = {1'b0, elapsed_ms} + 17'd1;

  always_comb begin
    upd.count   = count_reg;
    upd.illegal = is_sample && (code == STEP_ILLEGAL);
    upd.fire    = func && (elapsed_inc > {1'b0, window});
    upd.delta   = count_reg - count_snapshot;
    upd.error   = error_reg + {15'd0, upd.illegal};
    if (is_sample) begin
      unique case (code)
        STEP_UP:   upd.count = count_reg + 32'd1;
        STEP_DOWN: upd.count = count_reg - 32'd1;
        default:   upd.count = count_reg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_ab    <= 2'd0;
      count_reg      <= 32'd0;
      error_reg      <= 16'd0;
      elapsed_ms     <= 16'd0;
      count_snapshot <= 32'd0;
    end else if (accept) begin
      count_reg <= upd.count;
      error_reg <= upd.error;
      if (is_sample) begin
        previous_ab <= ab;
      end else if (upd.fire) begin
        elapsed_ms     <= 16'd0;
        count_snapshot <= count_reg;
      end else begin
        elapsed_ms <= elapsed_inc[15:0];
      end
    end
  end

  // illegal jump never moves the count
  `QEPV_ASSERT_NEXT(a_illegal_holds_count, accept && upd.illegal,
                    count_reg == $past(count_reg))
  // error count moves by exactly the illegal flag
  `QEPV_ASSERT_NEXT(a_error_step, accept,
                    error_reg == $past(error_reg) + 16'($past(upd.illegal)))
  // window firing restarts the timer and takes the snapshot
  `QEPV_ASSERT_NEXT(a_fire_restart, accept && upd.fire,
                    elapsed_ms == 16'd0 && count_snapshot == $past(count_reg))

endmodule

`default_nettype wire

/* verif/quadrature_encoder_position_velocity_top_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for quadrature_encoder_position_velocity_top: a directed table,
// then random phases under four idling modes, all scored against an untimed model.
// Depends on qepv_pkg (register indexes) and the RTL top level.

module quadrature_encoder_position_velocity_top_test;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int DRAIN_TAIL      = 16;   // margin after draining for stray results

  // quarter-turn difference between two AB codes, taken on their cycle positions
  localparam logic [1:0] QUARTER_FWD  = 2'd1;
  localparam logic [1:0] HALF_TURN    = 2'd2;
  localparam logic [1:0] QUARTER_BACK = 2'd3;

  typedef struct packed {
    logic [31:0] count;
    logic [31:0] degrees;
    logic [15:0] errors;
    logic [31:0] velocity;
    logic        illegal;
    logic        arrived;
  } reading_t;

  typedef struct packed {
    logic [15:0] window;
    logic [31:0] scale;
    logic [31:0] degrees;
    logic [31:0] target;
    logic [15:0] threshold;
  } settings_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_TYPED, ROW_SETTINGS} row_kind_e;

  typedef struct packed {
    row_kind_e kind;
    logic      func;
    logic      pin_a;
    logic      pin_b;
    reading_t  want;
    settings_t regs;
  } plan_row_t;

  // ---------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           wr_en = 1'b0;
  logic [qepv_pkg::CFG_IDX_W-1:0] wr_index = '0;
  logic [31:0]                    wr_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           func = 1'b0;
  logic                           pin_a = 1'b0;
  logic                           pin_b = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic signed [31:0]             position_count;
  logic signed [31:0]             position_degrees;
  logic        [15:0]             error_total;
  logic signed [31:0]             velocity;
  logic                           illegal_step;
  logic                           at_target;

  quadrature_encoder_position_velocity_top DUT (
    .clk              (clk),
    .rst              (rst),
    .wr_en            (wr_en),
    .wr_index         (wr_index),
    .wr_data          (wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .func             (func),
    .pin_a            (pin_a),
    .pin_b            (pin_b),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .position_count   (position_count),
    .position_degrees (position_degrees),
    .error_total      (error_total),
    .velocity         (velocity),
    .illegal_step     (illegal_step),
    .at_target        (at_target)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Encoder model: its own copy of registers and state, reset values included
  // ---------------------------------------------------------------------------
  logic [15:0] win_ms        = 16'd10;
  logic [31:0] vel_scale     = 32'd0;
  logic [31:0] deg_per_count = 32'h0001_0000;
  logic [31:0] target_pos    = 32'd0;
  logic [15:0] arrive_thr    = 16'd0;

  logic [1:0]  enc_prev_ab   = 2'd0;
  logic [31:0] enc_count     = 32'd0;
  logic [15:0] enc_errors    = 16'd0;
  logic [15:0] tick_elapsed  = 16'd0;
  logic [31:0] snap_count    = 32'd0;
  logic [31:0] enc_velocity  = 32'd0;

  reading_t pending_readings[$];   // one per accepted request, oldest first

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_serial   = 0;           // bumped by the sender to ask for a long hold-off
  int mismatches    = 0;
  int results_seen  = 0;
  int cycle_count   = 0;

  // signed value times unsigned factor, shifted down, truncated toward zero and
  // clamped to the signed 32-bit range
  function automatic logic [31:0] clamp_product(input logic [31:0] value,
                                                input logic [31:0] factor, input int sh);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] q;
    neg = value[31];
    mag = {32'd0, neg ? 32'd0 - value : value};
    q = (mag * {32'd0, factor}) >> sh;
    if (neg) return (q > 64'h8000_0000) ? 32'h8000_0000 : 32'd0 - q[31:0];
    return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
  endfunction

  // advance the model by one request and return the reading it produces
  function automatic reading_t predict_reading(input logic f, input logic a, input logic b);
    reading_t           r;
    logic [1:0]         ab;
    logic [1:0]         turn;
    logic [16:0]        next_ms;
    logic signed [63:0] gap;
    logic [63:0]        gap_mag;
    r.illegal = 1'b0;
    if (!f) begin
      ab = {a, b};
      // AB walks 00-01-11-10; compare positions on that cycle
      turn = {ab[1], ab[1] ^ ab[0]} - {enc_prev_ab[1], enc_prev_ab[1] ^ enc_prev_ab[0]};
      case (turn)
        QUARTER_FWD:  enc_count = enc_count + 32'd1;
        QUARTER_BACK: enc_count = enc_count - 32'd1;
        HALF_TURN: begin
          enc_errors = enc_errors + 16'd1;
          r.illegal  = 1'b1;
        end
        default: ;
      endcase
      enc_prev_ab = ab;
    end else begin
      // one extra bit so a window of 65535 still fires
      next_ms = {1'b0, tick_elapsed} + 17'd1;
      if (next_ms > {1'b0, win_ms}) begin
        enc_velocity = clamp_product(enc_count - snap_count, vel_scale, 8);
        tick_elapsed = 16'd0;
        snap_count   = enc_count;
      end else begin
        tick_elapsed = next_ms[15:0];
      end
    end
    gap     = $signed({{32{target_pos[31]}}, target_pos}) - $signed({{32{enc_count[31]}}, enc_count});
    gap_mag = gap[63] ? -gap : gap;
    r.count    = enc_count;
    r.degrees  = clamp_product(enc_count, deg_per_count, 16);
    r.errors   = enc_errors;
    r.velocity = enc_velocity;
    r.arrived  = gap_mag < {48'd0, arrive_thr};
    return r;
  endfunction

  // next AB code one quarter step forward or back
  function automatic logic [1:0] ab_after(input logic [1:0] ab, input logic up);
    logic [1:0] p;
    p = {ab[1], ab[1] ^ ab[0]};
    p = up ? p + 2'd1 : p - 2'd1;
    return {p[1], p[1] ^ p[0]};
  endfunction

  // ---------------------------------------------------------------------------
  // Directed-table row builders
  // ---------------------------------------------------------------------------
  function automatic plan_row_t item_row(input logic f, input logic a, input logic b);
    plan_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.func = f;
    row.pin_a = a;
    row.pin_b = b;
    return row;
  endfunction

  function automatic plan_row_t typed_row(input logic f, input logic a, input logic b,
                                          input reading_t want);
    plan_row_t row;
    row = item_row(f, a, b);
    row.kind = ROW_TYPED;
    row.want = want;
    return row;
  endfunction

  function automatic plan_row_t settings_row(input settings_t s);
    plan_row_t row;
    row = '0;
    row.kind = ROW_SETTINGS;
    row.regs = s;
    return row;
  endfunction

  // random register set; the target usually lands near the current count so arrival toggles
  function automatic settings_t random_settings();
    settings_t   s;
    logic [31:0] r;
    r = $urandom_range(12, 2);
    case ($urandom_range(3))
      0:       s.window = 16'd0;
      1:       s.window = 16'd1;
      default: s.window = r[15:0];
    endcase
    case ($urandom_range(3))
      0:       s.scale = 32'd0;
      1:       s.scale = 32'hFFFF_FFFF;
      2:       s.scale = 32'h0100_0000;
      default: s.scale = $urandom;
    endcase
    case ($urandom_range(3))
      0:       s.degrees = 32'd0;
      1:       s.degrees = 32'hFFFF_FFFF;
      2:       s.degrees = $urandom_range(32'h0004_0000);
      default: s.degrees = $urandom;
    endcase
    case ($urandom_range(5))
      0:       s.target = 32'h8000_0000;
      1:       s.target = 32'h7FFF_FFFF;
      default: s.target = enc_count + $urandom_range(60) - 32'd30;
    endcase
    r = $urandom_range(25, 1);
    case ($urandom_range(3))
      0:       s.threshold = 16'd0;
      1:       s.threshold = 16'hFFFF;
      default: s.threshold = r[15:0];
    endcase
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one request, hold it until accepted, then queue its expected reading.
  // Returns in the time step of the accepting edge with in_valid still high.
  task automatic send_request(input logic f, input logic a, input logic b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    pin_a    <= a;
    pin_b    <= b;
    do @(posedge clk); while (!in_ready);
    pending_readings.push_back(predict_reading(f, a, b));
  endtask

  // drop valid and wait until every queued reading has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_readings.size() != 0);
  endtask

  // write all five registers, one per cycle; only called with the block idle
  task automatic program_regs(input settings_t s);
    wr_en    <= 1'b1;
    wr_index <= qepv_pkg::REG_VELOCITY_WINDOW_MS;
    wr_data  <= {16'd0, s.window};
    @(posedge clk);
    win_ms   = s.window;
    wr_index <= qepv_pkg::REG_VELOCITY_SCALE;
    wr_data  <= s.scale;
    @(posedge clk);
    vel_scale = s.scale;
    wr_index <= qepv_pkg::REG_DEG_FACTOR;
    wr_data  <= s.degrees;
    @(posedge clk);
    deg_per_count = s.degrees;
    wr_index <= qepv_pkg::REG_GOAL_POSITION;
    wr_data  <= s.target;
    @(posedge clk);
    target_pos = s.target;
    wr_index <= qepv_pkg::REG_ARRIVAL_THRESHOLD;
    wr_data  <= {16'd0, s.threshold};
    @(posedge clk);
    arrive_thr = s.threshold;
    wr_en    <= 1'b0;
  endtask

  // Mostly clean quadrature runs (direction flips now and then), plus holds,
  // ticks with junk on the pins, and random samples that may jump two codes.
  task automatic random_burst(input int n);
    logic        heading;
    logic [31:0] noise;
    int          pick;
    logic [1:0]  ab;
    heading = $urandom_range(1);
    for (int i = 0; i < n; i++) begin
      pick  = $urandom_range(99);
      noise = $urandom;
      if ($urandom_range(9) == 0) heading = ~heading;
      if (pick < 55) begin
        ab = ab_after(enc_prev_ab, heading);
        send_request(1'b0, ab[1], ab[0]);
      end else if (pick < 65) begin
        send_request(1'b0, enc_prev_ab[1], enc_prev_ab[0]);
      end else if (pick < 85) begin
        send_request(1'b1, noise[0], noise[1]);
      end else begin
        send_request(1'b0, noise[0], noise[1]);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    plan_row_t  plan[$];
    int         mode;
    int         chunk;

    // Directed table. Rows with typed readings run at reset settings, where the
    // values can be read straight off the step table.
    // Forward lap 00-01-11-10-00, one step back, two double-code jumps.
    plan.push_back(typed_row(1'b0, 1'b0, 1'b0, {32'd0, 32'd0, 16'd0, 32'd0, 1'b0, 1'b0}));
    plan.push_back(typed_row(1'b0, 1'b0, 1'b1, {32'd1, 32'd1, 16'd0, 32'd0, 1'b0, 1'b0}));
    plan.push_back(typed_row(1'b0, 1'b1, 1'b1, {32'd2, 32'd2, 16'd0, 32'd0, 1'b0, 1'b0}));
    plan.push_back(typed_row(1'b0, 1'b1, 1'b0, {32'd3, 32'd3, 16'd0, 32'd0, 1'b0, 1'b0}));
    plan.push_back(typed_row(1'b0, 1'b0, 1'b0, {32'd4, 32'd4, 16'd0, 32'd0, 1'b0, 1'b0}));
    plan.push_back(typed_row(1'b0, 1'b1, 1'b0, {32'd3, 32'd3, 16'd0, 32'd0, 1'b0, 1'b0}));
    plan.push_back(typed_row(1'b0, 1'b0, 1'b1, {32'd3, 32'd3, 16'd1, 32'd0, 1'b1, 1'b0}));
    plan.push_back(typed_row(1'b0, 1'b1, 1'b0, {32'd3, 32'd3, 16'd2, 32'd0, 1'b1, 1'b0}));
    // tick: pins would mean a step if sampled, must be ignored
    plan.push_back(typed_row(1'b1, 1'b1, 1'b1, {32'd3, 32'd3, 16'd2, 32'd0, 1'b0, 1'b0}));
    plan.push_back(item_row(1'b0, 1'b1, 1'b1));
    plan.push_back(item_row(1'b0, 1'b0, 1'b0));   // 11 -> 00 jump
    // zero window (velocity every tick), full-scale factors, extreme target,
    // widest threshold
    plan.push_back(settings_row({16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 16'hFFFF}));
    plan.push_back(item_row(1'b1, 1'b0, 1'b0));
    plan.push_back(item_row(1'b0, 1'b1, 1'b1));   // 00 -> 11 jump
    plan.push_back(item_row(1'b0, 1'b1, 1'b0));
    plan.push_back(item_row(1'b1, 1'b1, 1'b0));
    plan.push_back(item_row(1'b0, 1'b1, 1'b1));
    plan.push_back(item_row(1'b1, 1'b0, 1'b1));   // negative delta
    // window of one, unit scale, zero degrees factor, top target, zero threshold
    plan.push_back(settings_row({16'd1, 32'h0100_0000, 32'd0, 32'h7FFF_FFFF, 16'd0}));
    plan.push_back(item_row(1'b0, 1'b0, 1'b1));
    plan.push_back(item_row(1'b1, 1'b1, 1'b1));
    plan.push_back(item_row(1'b1, 1'b1, 1'b1));
    // arrival edges around a near target, half-degree factor
    plan.push_back(settings_row({16'd10, 32'h0080_0000, 32'h0000_8000, 32'd4, 16'd2}));
    plan.push_back(item_row(1'b0, 1'b0, 1'b0));
    plan.push_back(item_row(1'b0, 1'b0, 1'b1));
    plan.push_back(item_row(1'b0, 1'b1, 1'b1));
    plan.push_back(item_row(1'b1, 1'b0, 1'b0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_SETTINGS: begin
          wait_drained();
          program_regs(plan[i].regs);
        end
        ROW_TYPED: begin
          send_request(plan[i].func, plan[i].pin_a, plan[i].pin_b);
          // the newest entry is this request's; the typed reading takes its place
          pending_readings[pending_readings.size() - 1] = plan[i].want;
        end
        default: send_request(plan[i].func, plan[i].pin_a, plan[i].pin_b);
      endcase
    end

    // Random part: four idling modes, four register sets each.
    for (mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 59; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 59; end
        default: begin send_idle_pct = 18; stall_pct = 18; end
      endcase
      for (chunk = 0; chunk < 4; chunk++) begin
        wait_drained();
        program_regs(random_settings());
        if (mode == 0 && chunk == 1) hold_serial++;   // receiver backs off, pipe fills
        if (mode == 0 && chunk == 2) begin
          random_burst(48);
          wait_drained();                              // sender rests until empty
          random_burst(49);
        end else begin
          random_burst(97);
        end
      end
    end

    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls per mode, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  int seen_serial = 0;
  int hold_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_serial != seen_serial) begin
        seen_serial = hold_serial;
        hold_left   = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Scoreboard: every accepted result against the oldest expected reading
  // ---------------------------------------------------------------------------
  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d, %s: expected 0x%08h, got 0x%08h", results_seen, name, want, got);
    end
  endtask

  always @(posedge clk) begin : score_results
    reading_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with no request outstanding (count 0x%08h)",
                   results_seen, position_count);
      end else begin
        want = pending_readings.pop_front();
        report_field("position_count",   want.count,            position_count);
        report_field("position_degrees", want.degrees,          position_degrees);
        report_field("error_total",      {16'd0, want.errors},  {16'd0, error_total});
        report_field("velocity",         want.velocity,         velocity);
        report_field("illegal_step",     {31'd0, want.illegal}, {31'd0, illegal_step});
        report_field("at_target",        {31'd0, want.arrived}, {31'd0, at_target});
      end
      results_seen++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule

/* files.f */
+incdir+src
src/qepv_pkg.sv
src/qepv_track.sv
src/quadrature_encoder_position_velocity_top.sv
verif/quadrature_encoder_position_velocity_top_test.sv
